// ===== rtl/core/apq_pkg.sv =====
// Shared types and codes for the array priority queue.
// No dependencies; imported by apq_cell and array_priority_queue.
package apq_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 4;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_NEXT,
    CELL_HEAD
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CLOSE
  } state_t;

endpackage

// ===== rtl/core/apq_cell.sv =====
// One storage cell of the queue chain: holds a (data, priority) entry.
// Depends on apq_pkg for entry_t and cell_op_t.
module apq_cell (
  input  logic              clk,
  input  apq_pkg::cell_op_t op,
  input  apq_pkg::entry_t   load_in,
  input  apq_pkg::entry_t   next_in,
  input  apq_pkg::entry_t   head_in,
  output apq_pkg::entry_t   entry
);
  import apq_pkg::*;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD: entry <= entry;
      CELL_LOAD: entry <= load_in;
      CELL_NEXT: entry <= next_in;
      CELL_HEAD: entry <= head_in;
      default:   entry <= entry;
    endcase
  end

endmodule

// ===== rtl/core/array_priority_queue.sv =====
// Array priority queue: insertion-ordered chain of cells, remove of the maximum priority.
// Insert: result in the cycle after acceptance; busy does not rise.
// Remove: S_SCAN rotates the chain through every held entry, comparing each at the head,
// then S_CLOSE closes the gap; the result is registered from S_CLOSE, busy through both.
// Full or empty reports: result in the cycle after acceptance. The receiver cannot stall.
// Reset (rst, synchronous) empties the queue; entry storage is not cleared.
module array_priority_queue #(
  parameter int DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               action,
  input  logic signed [apq_pkg::DATA_W-1:0]  item_value,
  input  logic signed [apq_pkg::DATA_W-1:0]  item_priority,
  output logic                               done,
  output logic [1:0]                         status,
  output logic signed [apq_pkg::DATA_W-1:0]  removed_value,
  output logic signed [apq_pkg::DATA_W-1:0]  removed_priority,
  output logic [apq_pkg::OCC_W-1:0]          occupancy
);
  import apq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  state_t                     state, state_next;
  logic [CNT_W-1:0]           count, count_next;
  logic [IDX_W-1:0]           step, step_next;
  logic [IDX_W-1:0]           best_idx, best_idx_next;
  entry_t                     best, best_next;
  logic                       done_next;
  logic [1:0]                 status_next;
  logic signed [DATA_W-1:0]   removed_value_next, removed_priority_next;
  logic [OCC_W-1:0]           occupancy_next;

  entry_t                     cells [DEPTH];
  cell_op_t                   cell_ops [DEPTH];
  entry_t                     item_in;

  assign item_in = '{data: item_value, prio: item_priority};
  assign busy    = (state != S_IDLE);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int NXT = (i + 1 < DEPTH) ? i + 1 : i;

    always_comb begin
      priority if (state == S_IDLE && start && action == ACT_INSERT &&
                   count == CNT_W'(i)) begin
        cell_ops[i] = CELL_LOAD;
      end else if (state == S_SCAN && CNT_W'(i + 1) == count) begin
        cell_ops[i] = CELL_HEAD;
      end else if (state == S_SCAN && CNT_W'(i + 1) < count) begin
        cell_ops[i] = CELL_NEXT;
      end else if (state == S_CLOSE && IDX_W'(i) >= best_idx &&
                   CNT_W'(i + 1) < count) begin
        cell_ops[i] = CELL_NEXT;
      end else begin
        cell_ops[i] = CELL_HOLD;
      end
    end

    apq_cell u_cell (
      .clk     (clk),
      .op      (cell_ops[i]),
      .load_in (item_in),
      .next_in (cells[NXT]),
      .head_in (cells[0]),
      .entry   (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    step             <= step_next;
    best_idx         <= best_idx_next;
    best             <= best_next;
    status           <= status_next;
    removed_value    <= removed_value_next;
    removed_priority <= removed_priority_next;
    occupancy        <= occupancy_next;
  end

  always_comb begin
    state_next            = state;
    count_next            = count;
    step_next             = step;
    best_idx_next         = best_idx;
    best_next             = best;
    done_next             = 1'b0;
    status_next           = status;
    removed_value_next    = removed_value;
    removed_priority_next = removed_priority;
    occupancy_next        = occupancy;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (action == ACT_INSERT) begin
            done_next             = 1'b1;
            removed_value_next    = '0;
            removed_priority_next = '0;
            if (count == CNT_W'(DEPTH)) begin
              status_next = ST_FULL;
            end else begin
              status_next = ST_DONE;
              count_next  = count + 1'b1;
            end
          end else if (count == '0) begin
            done_next             = 1'b1;
            status_next           = ST_EMPTY;
            removed_value_next    = '0;
            removed_priority_next = '0;
          end else begin
            state_next = S_SCAN;
            step_next  = '0;
          end
          occupancy_next = OCC_W'(count_next);
        end
      end
      S_SCAN: begin
        if (step == '0 || cells[0].prio > best.prio) begin
          best_next     = cells[0];
          best_idx_next = step;
        end
        step_next = step + 1'b1;
        if (CNT_W'(step) == count - 1'b1) begin
          state_next = S_CLOSE;
        end
      end
      S_CLOSE: begin
        count_next            = count - 1'b1;
        done_next             = 1'b1;
        status_next           = ST_DONE;
        removed_value_next    = best.data;
        removed_priority_next = best.prio;
        occupancy_next        = OCC_W'(count_next);
        state_next            = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
